### hdl/paps_pkg.sv
// Package for the pseudo-angle point sorter: widths, register indexes, types.
// No dependencies.
package paps_pkg;
  localparam int KEY_BITS  = 19;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ANCHOR_X = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ANCHOR_Y = 2'd2;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [1:0] {ST_LOAD, ST_DRAIN, ST_EMIT} state_t;

  // control from sequencer to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast item
    logic shift;  // shift towards cell 0 (drain)
  } cell_ctl_t;
endpackage

### hdl/paps_key_unit.sv
// Sort-key unit: x key, or pseudo-angle about the anchor via a restoring divider.
// Depends on paps_pkg. One quotient bit per cycle, COORD_BITS+17 steps after setup.
module paps_key_unit #(
  parameter int COORD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  logic [COORD_BITS-1:0] ax,
  input  logic [COORD_BITS-1:0] ay,
  output logic                  busy,
  output logic                  done,
  output paps_pkg::key_t        key
);
  import paps_pkg::*;
  localparam int SB = COORD_BITS + 1;
  localparam int QB = FRAC_BITS + 1;
  localparam int CB = $clog2(SB + FRAC_BITS);

  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic [SB-1:0] div_r, div_nxt;   // divisor |dx|+|dy|
  logic [SB-1:0] rem_r, rem_nxt;
  logic [SB-1:0] num_r, num_nxt;   // |dy| shifted up bit by bit
  logic [QB-1:0] q_r, q_nxt;
  logic          xneg_r, xneg_nxt, yneg_r, yneg_nxt, yz_r, yz_nxt;
  key_t          key_r, key_nxt;

  logic [SB-1:0] adx, ady;
  logic [SB:0]   trial;
  logic [QB-1:0] m;

  always_comb begin
    adx = (px >= ax) ? SB'(px - ax) : SB'(ax - px);
    ady = (py >= ay) ? SB'(py - ay) : SB'(ay - py);
  end

  always_comb begin
    busy_nxt = busy_r; done_nxt = 1'b0; cnt_nxt = cnt_r; div_nxt = div_r;
    rem_nxt = rem_r; num_nxt = num_r; q_nxt = q_r; key_nxt = key_r;
    xneg_nxt = xneg_r; yneg_nxt = yneg_r; yz_nxt = yz_r;
    trial = {rem_r, 1'b0} | {{SB{1'b0}}, num_r[SB-1]};
    m = q_r;
    if (start) begin
      if (!mode) begin
        key_nxt  = KEY_BITS'(px);
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1; cnt_nxt = '0; rem_nxt = '0; q_nxt = '0;
        div_nxt  = adx + ady; num_nxt = ady;
        xneg_nxt = px < ax; yneg_nxt = py < ay; yz_nxt = py == ay;
      end
    end else if (busy_r) begin
      // one quotient bit of |dy|*2^16 / s
      if (div_r != '0 && trial >= {1'b0, div_r}) begin
        rem_nxt = SB'(trial - {1'b0, div_r});
        q_nxt   = {q_r[QB-2:0], 1'b1};
      end else begin
        rem_nxt = SB'(trial);
        q_nxt   = {q_r[QB-2:0], 1'b0};
      end
      num_nxt = num_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CB'(SB + FRAC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        m = (div_r == '0) ? '0 : q_nxt;
        if (xneg_r)
          key_nxt = yneg_r ? KEY_BITS'(131072) + KEY_BITS'(m)
                           : KEY_BITS'(131072) - KEY_BITS'(m);
        else if (yneg_r || yz_r)
          key_nxt = KEY_BITS'(262144) - KEY_BITS'(m);
        else
          key_nxt = KEY_BITS'(m);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    div_r <= div_nxt; rem_r <= rem_nxt; num_r <= num_nxt; q_r <= q_nxt;
    key_r <= key_nxt; xneg_r <= xneg_nxt; yneg_r <= yneg_nxt; yz_r <= yz_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign key  = key_r;
endmodule

### hdl/paps_cell.sv
// One insertion cell: holds a point and its key, takes the new item or the
// left neighbour's entry on insert, or the right neighbour's on drain. Depends on paps_pkg.
module paps_cell #(
  parameter int COORD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  paps_pkg::cell_ctl_t   ctl,
  input  logic [COORD_BITS-1:0] new_x,
  input  logic [COORD_BITS-1:0] new_y,
  input  paps_pkg::key_t        new_key,
  input  logic                  prev_gt,  // left neighbour valid with key > new
  input  logic [COORD_BITS-1:0] prev_x,
  input  logic [COORD_BITS-1:0] prev_y,
  input  paps_pkg::key_t        prev_key,
  input  logic                  prev_vld,
  input  logic                  prev_is_first, // no left neighbour
  input  logic                  next_vld,      // right neighbour (drain)
  input  logic [COORD_BITS-1:0] next_x,
  input  logic [COORD_BITS-1:0] next_y,
  input  paps_pkg::key_t        next_key,
  output logic                  vld,
  output logic                  gt,
  output logic [COORD_BITS-1:0] x,
  output logic [COORD_BITS-1:0] y,
  output paps_pkg::key_t        key
);
  import paps_pkg::*;
  logic                  vld_r, vld_nxt;
  logic [COORD_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  key_t                  key_r, key_nxt;
  logic                  first_free;

  assign gt = vld_r && (key_r > new_key);
  // this cell is the first free one (entries are packed from cell 0)
  assign first_free = !vld_r && (prev_is_first || prev_vld);

  always_comb begin
    vld_nxt = vld_r; x_nxt = x_r; y_nxt = y_r; key_nxt = key_r;
    if (ctl.shift) begin
      vld_nxt = next_vld; x_nxt = next_x; y_nxt = next_y; key_nxt = next_key;
    end else if (ctl.ins) begin
      if (prev_gt) begin
        vld_nxt = prev_vld; x_nxt = prev_x; y_nxt = prev_y; key_nxt = prev_key;
      end else if (gt || first_free) begin
        vld_nxt = 1'b1; x_nxt = new_x; y_nxt = new_y; key_nxt = new_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_nxt;
    x_r <= x_nxt; y_r <= y_nxt; key_r <= key_nxt;
  end

  assign vld = vld_r;
  assign x   = x_r;
  assign y   = y_r;
  assign key = key_r;
endmodule

### hdl/pseudo_angle_point_sorter_top.sv
// Channel | dir | payload (low bit first)
// in_     | in  | tdata {point_x, point_y}, tlast = set_end
// out_    | out | tdata {out_x, out_y, out_key, pad}, tlast = out_last, tuser = overflow
// cfg_    | in  | index 0 key_mode, 1 anchor_x, 2 anchor_y
// In x mode the key is the point's x coordinate; in pseudo-angle mode the key unit's
// bit-serial divider computes it. A new point is taken only once the last one is inserted.
// After set end the chain drains towards cell 0, one point per out_ request.
// rst_n is synchronous; it clears the chain valid bits, state, count, flags and config.
// out_tready low holds the head cell; input is refused while draining.
// Depends on paps_pkg, paps_key_unit, paps_cell.
module pseudo_angle_point_sorter_top #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] in_tdata, // point_x, point_y
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [((2*COORD_BITS+19+7)/8)*8-1:0] out_tdata, // out_x, out_y, out_key
  output logic                             out_tlast,
  output logic                             out_tuser, // overflow
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [paps_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);
  import paps_pkg::*;
  localparam int OW = ((2*COORD_BITS+KEY_BITS+7)/8)*8;
  localparam int N  = MAX_POINTS;
  localparam int CW = $clog2(N + 1);

  state_t state_r, state_nxt;
  logic   mode_r;
  logic [COORD_BITS-1:0] ax_r, ay_r;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic   last_r, last_nxt, ovf_r, ovf_nxt, pend_r, pend_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic   kstart, kbusy, kdone;
  key_t   kkey;
  cell_ctl_t ctl;

  // configuration
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; ax_r <= '0; ay_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_MODE: mode_r <= cfg_data[0];
        REG_ANCHOR_X: ax_r   <= cfg_data[COORD_BITS-1:0];
        REG_ANCHOR_Y: ay_r   <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  paps_key_unit #(.COORD_BITS(COORD_BITS)) u_key (
    .clk, .rst_n, .start(kstart), .mode(mode_r),
    .px(in_tdata[COORD_BITS-1:0]), .py(in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .ax(ax_r), .ay(ay_r), .busy(kbusy), .done(kdone), .key(kkey));

  // cell chain
  logic [N-1:0] vld, gt;
  logic [COORD_BITS-1:0] cx [N];
  logic [COORD_BITS-1:0] cy [N];
  key_t ck [N];
  logic full;
  assign full = cnt_r == CW'(N);

  for (genvar i = 0; i < N; i++) begin : g_cell
    paps_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk, .rst_n, .ctl,
      .new_x(px_r), .new_y(py_r), .new_key(kkey),
      .prev_gt(i == 0 ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .prev_x(cx[(i == 0) ? 0 : i-1]), .prev_y(cy[(i == 0) ? 0 : i-1]),
      .prev_key(ck[(i == 0) ? 0 : i-1]), .prev_vld(vld[(i == 0) ? 0 : i-1]),
      .prev_is_first(i == 0),
      .next_vld(i == N-1 ? 1'b0 : vld[(i == N-1) ? i : i+1]),
      .next_x(cx[(i == N-1) ? i : i+1]), .next_y(cy[(i == N-1) ? i : i+1]),
      .next_key(ck[(i == N-1) ? i : i+1]),
      .vld(vld[i]), .gt(gt[i]), .x(cx[i]), .y(cy[i]), .key(ck[i]));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; last_nxt = last_r; ovf_nxt = ovf_r; cnt_nxt = cnt_r;
    pend_nxt = pend_r;
    kstart = 1'b0; ctl = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = !kbusy && !kdone && !pend_r;
        if (in_tvalid && in_tready) begin
          kstart = 1'b1; pend_nxt = 1'b1; last_nxt = in_tlast;
        end
        if (kdone) begin
          pend_nxt = 1'b0;
          if (full) ovf_nxt = 1'b1;
          else begin
            ctl.ins = 1'b1; cnt_nxt = cnt_r + 1'b1;
          end
          if (last_r) begin
            state_nxt = ST_EMIT;
            if (full) ovf_nxt = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          ctl.shift = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            state_nxt = ST_LOAD; ovf_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; cnt_r <= '0; ovf_r <= 1'b0; pend_r <= 1'b0; last_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt;
      pend_r <= pend_nxt; last_r <= last_nxt;
    end
  end

  // input point held for the insert
  always_ff @(posedge clk) begin
    if (kstart) begin
      px_r <= in_tdata[COORD_BITS-1:0];
      py_r <= in_tdata[2*COORD_BITS-1:COORD_BITS];
    end
  end

  assign out_tvalid = state_r == ST_EMIT;
  assign out_tdata  = OW'({ck[0], cy[0], cx[0]});
  assign out_tlast  = cnt_r == CW'(1);
  assign out_tuser  = ovf_r;
endmodule

### hdl/paps_checker.sv
// Port checker for the point sorter, bound to the top level.
// Depends on pseudo_angle_point_sorter_top ports only.
module paps_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tlast
);
  // no input taken while results are pending
  a_no_in_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input accepted during emission");
  // a result stays offered while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  // after the last result, emission stops
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid) else $error("run overran");
endmodule

bind pseudo_angle_point_sorter_top paps_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tlast);

### tb/sv/pseudo_angle_point_sorter_top_tb.sv
// Testbench for pseudo_angle_point_sorter_top: drives point sets with random idling,
// predicts the sorted runs with its own insertion sort and checks each out_ request.
// Depends on paps_pkg and the top level RTL.
module pseudo_angle_point_sorter_top_tb;
  import paps_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int IN_BITS    = 16;
  localparam int OUT_BITS   = 40;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    logic [7:0] x;
    logic [7:0] y;
    key_t       key;
    logic       last;
    logic       ovf;
  } sorted_pt_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_BITS-1:0]    in_tdata;  // point_x, point_y
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_BITS-1:0]   out_tdata; // out_x, out_y, out_key
  logic                  out_tlast;
  logic                  out_tuser; // overflow
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [31:0]           cfg_data;

  // predictor state
  sorted_pt_t sort_buf[$];
  logic       drop_seen;
  logic       mode_q;
  logic [7:0] anc_x_q;
  logic [7:0] anc_y_q;
  sorted_pt_t run_queue[$];

  int  error_count;
  int  quiet_cycles = 0;
  int  out_idle_left;
  bit  idle_enable;

  pseudo_angle_point_sorter_top #(.MAX_POINTS(CAPACITY), .COORD_BITS(8)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // pseudo-angle key, 16 fraction bits
  function automatic key_t angle_key(logic [7:0] px, logic [7:0] py);
    int dx, dy, ax, ay, s, m;
    dx = int'(px) - int'(anc_x_q);
    dy = int'(py) - int'(anc_y_q);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    s  = ax + ay;
    m  = (s != 0) ? (ay * 65536) / s : 0;
    if (dx < 0) return dy < 0 ? key_t'(131072 + m) : key_t'(131072 - m);
    if (dy <= 0) return key_t'(262144 - m);
    return key_t'(m);
  endfunction

  // insert into sorted buffer; emit the run on set end
  task automatic predict_point(logic [7:0] px, logic [7:0] py, logic set_end);
    sorted_pt_t p;
    int pos;
    p.x = px; p.y = py; p.last = 1'b0; p.ovf = 1'b0;
    p.key = mode_q ? angle_key(px, py) : key_t'(px);
    if (sort_buf.size() >= CAPACITY) begin
      drop_seen = 1'b1;
    end else begin
      pos = sort_buf.size();
      while (pos > 0 && sort_buf[pos-1].key > p.key) pos--;
      sort_buf.insert(pos, p);
    end
    if (set_end) begin
      foreach (sort_buf[i]) begin
        p = sort_buf[i];
        p.last = (i == sort_buf.size() - 1);
        p.ovf = drop_seen;
        run_queue.push_back(p);
      end
      sort_buf.delete();
      drop_seen = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what);
    error_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic idle_burst();
    repeat ($urandom_range(1, 3)) @(posedge clk);
  endtask

  // one point request; tvalid stays up until the next idle gap or drain
  task automatic send_point(logic [7:0] px, logic [7:0] py, logic set_end);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      idle_burst();
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {py, px};
    in_tlast  <= set_end;
    do @(posedge clk); while (!in_tready);
    predict_point(px, py, set_end);
  endtask

  // one register write; set_config drops cfg_valid after the last one
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY_MODE: mode_q  = val[0];
      REG_ANCHOR_X: anc_x_q = val[7:0];
      REG_ANCHOR_Y: anc_y_q = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain_runs();
    in_tvalid <= 1'b0;
    while (run_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic m, logic [7:0] ax, logic [7:0] ay);
    drain_runs();
    write_reg(REG_KEY_MODE, {31'd0, m});
    write_reg(REG_ANCHOR_X, {24'd0, ax});
    write_reg(REG_ANCHOR_Y, {24'd0, ay});
    cfg_valid <= 1'b0;
  endtask

  // directed: extremes, ties, anchor point, each quadrant
  task automatic test_directed();
    set_config(1'b0, 8'd0, 8'd0);
    send_point(8'd255, 8'd0, 1'b0);
    send_point(8'd0, 8'd255, 1'b0);
    send_point(8'd7, 8'd1, 1'b0);
    send_point(8'd7, 8'd2, 1'b0);
    send_point(8'd7, 8'd3, 1'b1);
    send_point(8'd128, 8'd128, 1'b1);
    set_config(1'b1, 8'd128, 8'd128);
    send_point(8'd128, 8'd128, 1'b0);
    send_point(8'd200, 8'd200, 1'b0);
    send_point(8'd10, 8'd200, 1'b0);
    send_point(8'd10, 8'd10, 1'b0);
    send_point(8'd200, 8'd10, 1'b0);
    send_point(8'd128, 8'd255, 1'b0);
    send_point(8'd0, 8'd128, 1'b0);
    send_point(8'd128, 8'd0, 1'b0);
    send_point(8'd255, 8'd128, 1'b1);
    set_config(1'b1, 8'd255, 8'd255);
    send_point(8'd0, 8'd0, 1'b0);
    send_point(8'd255, 8'd255, 1'b1);
    set_config(1'b1, 8'd0, 8'd0);
    send_point(8'd255, 8'd255, 1'b0);
    send_point(8'd0, 8'd0, 1'b1);
  endtask

  // a full store followed by dropped points, set end included
  task automatic test_overflow();
    set_config(1'b0, 8'd0, 8'd0);
    for (int i = 0; i < CAPACITY + 3; i++)
      send_point(8'($urandom), 8'($urandom), i == CAPACITY + 2);
  endtask

  // random sets; anchor moves mid-set are not allowed here, config between sets only
  task automatic test_random(int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 2) == 0)
        set_config(1'($urandom), 8'($urandom), 8'($urandom));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, CAPACITY + 4)
                                        : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_point(8'($urandom_range(0, 3) * 85), 8'($urandom), i == len - 1);
        else
          send_point(8'($urandom), 8'($urandom), i == len - 1);
      end
      sent += len;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    sorted_pt_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (run_queue.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = run_queue.pop_front();
        if (out_tdata[7:0] !== e.x) report_mismatch("out_x");
        if (out_tdata[15:8] !== e.y) report_mismatch("out_y");
        if (out_tdata[34:16] !== e.key) report_mismatch("out_key");
        if (out_tlast !== e.last) report_mismatch("out_last");
        if (out_tuser !== e.ovf) report_mismatch("overflow");
      end
    end
  end

  // receiver stalls at random in short bursts while idling is enabled
  always @(posedge clk) begin
    if (!rst_n || !idle_enable) begin
      out_tready <= 1'b1;
      out_idle_left <= 0;
    end else if (out_idle_left > 0) begin
      out_tready <= 1'b0;
      out_idle_left <= out_idle_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      out_idle_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any request
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    error_count = 0; idle_enable = 1'b1;
    drop_seen = 1'b0; mode_q = 1'b0; anc_x_q = '0; anc_y_q = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(270);
    idle_enable = 1'b0;
    test_random(60);
    drain_runs();
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

### files.f
hdl/paps_pkg.sv
hdl/paps_key_unit.sv
hdl/paps_cell.sv
hdl/pseudo_angle_point_sorter_top.sv
hdl/paps_checker.sv
tb/sv/pseudo_angle_point_sorter_top_tb.sv
